// ===== sv/npcs_pkg.sv =====
// Package for the nearest palette color search block.
// Holds the transfer payload structs and the command codes; no dependencies.
package npcs_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] slot;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       color_ok;
  } in_t;

  typedef struct packed {
    logic [7:0]  best_index;
    logic        found;
    logic [17:0] nearest_dist;
  } out_t;

endpackage

// ===== sv/nearest_palette_color_search.sv =====
// Nearest palette color search: clear, load and query of an ordered palette list.
// Uses npcs_pkg and two npcs_ram instances (entry list and slot colors).
// Clear and load are taken while idle. A query with an empty list goes straight to the
// finish step; otherwise one distance unit walks one entry per cycle.
// Not ready while a query runs. Reset empties the list and marks all slot
// colors as zero at once through per-slot valid bits; no clearing pass.
module nearest_palette_color_search #(
  parameter int MAX_ENTRIES = 64,
  parameter int SLOT_COUNT  = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  npcs_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output npcs_pkg::out_t out_data_o
);

  localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [CW-1:0] cnt_q, iss_q;
  logic [SLOT_COUNT-1:0] vld_q;
  logic        p1_q, p2_q, p3_q;
  logic [7:0]  px_r_q, px_g_q, px_b_q;
  logic [7:0]  slot2_q, slot3_q;
  logic        cvld2_q;
  logic [17:0] dist3_q;
  logic        have_q;
  logic [17:0] best_d_q;
  logic [7:0]  best_s_q;
  logic        out_vld_q;
  npcs_pkg::out_t out_q;

  logic        in_acc, is_clear, is_load, is_query, load_ok;
  logic        ent_re, fin_go, run_done;
  logic [7:0]  ent_rdata;
  logic [23:0] col_rdata, col_eff;
  logic [17:0] dist_d;

  function automatic logic [15:0] sq_diff(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_clear = in_acc && (in_data_i.cmd == npcs_pkg::CMD_CLEAR);
  assign is_load  = in_acc && (in_data_i.cmd == npcs_pkg::CMD_LOAD);
  assign is_query = in_acc && (in_data_i.cmd == npcs_pkg::CMD_QUERY);
  assign load_ok  = is_load && (cnt_q < CW'(MAX_ENTRIES))
                    && (int'(in_data_i.slot) < SLOT_COUNT);

  assign in_stall_o = (state_q != ST_IDLE);
  assign ent_re     = (state_q == ST_RUN) && (iss_q != cnt_q);
  assign run_done   = (state_q == ST_RUN) && (iss_q == cnt_q) && !p1_q && !p2_q && !p3_q;
  assign fin_go     = (state_q == ST_FIN) && (!out_vld_q || !out_stall_i);

  npcs_ram #(.Width(8), .Depth(MAX_ENTRIES)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (load_ok),
    .waddr_i (cnt_q[EAW-1:0]),
    .wdata_i (in_data_i.slot),
    .re_i    (ent_re),
    .raddr_i (iss_q[EAW-1:0]),
    .rdata_o (ent_rdata)
  );

  npcs_ram #(.Width(24), .Depth(SLOT_COUNT)) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (load_ok && in_data_i.color_ok),
    .waddr_i (in_data_i.slot[SW-1:0]),
    .wdata_i ({in_data_i.red, in_data_i.green, in_data_i.blue}),
    .re_i    (p1_q),
    .raddr_i (ent_rdata[SW-1:0]),
    .rdata_o (col_rdata)
  );

  assign col_eff = cvld2_q ? col_rdata : 24'd0;
  assign dist_d  = 18'(sq_diff(px_r_q, col_eff[23:16]))
                 + 18'(sq_diff(px_g_q, col_eff[15:8]))
                 + 18'(sq_diff(px_b_q, col_eff[7:0]));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (is_query) begin
          state_d = (cnt_q == '0) ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      iss_q     <= '0;
      vld_q     <= '0;
      p1_q      <= 1'b0;
      p2_q      <= 1'b0;
      p3_q      <= 1'b0;
      have_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (is_clear) begin
        cnt_q <= '0;
        vld_q <= '0;
      end else if (load_ok) begin
        cnt_q <= cnt_q + CW'(1);
        if (in_data_i.color_ok) begin
          vld_q[in_data_i.slot[SW-1:0]] <= 1'b1;
        end
      end
      if (is_query) begin
        iss_q <= '0;
      end else if (ent_re) begin
        iss_q <= iss_q + CW'(1);
      end
      p1_q <= ent_re;
      p2_q <= p1_q;
      p3_q <= p2_q;
      if (is_query) begin
        have_q <= 1'b0;
      end else if (p3_q && (!have_q || (dist3_q < best_d_q))) begin
        have_q <= 1'b1;
      end
      if (fin_go) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      px_r_q   <= in_data_i.red;
      px_g_q   <= in_data_i.green;
      px_b_q   <= in_data_i.blue;
      best_d_q <= '0;
      best_s_q <= '0;
    end else if (p3_q && (!have_q || (dist3_q < best_d_q))) begin
      best_d_q <= dist3_q;
      best_s_q <= slot3_q;
    end
    if (p1_q) begin
      slot2_q <= ent_rdata;
      cvld2_q <= vld_q[ent_rdata[SW-1:0]];
    end
    if (p2_q) begin
      slot3_q <= slot2_q;
      dist3_q <= dist_d;
    end
    if (fin_go) begin
      out_q.best_index   <= best_s_q;
      out_q.found        <= have_q;
      out_q.nearest_dist <= best_d_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(p1_q || p2_q || p3_q))
    else $error("fetch pipeline busy while idle");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (iss_q <= cnt_q))
    else $error("entry walk ran past the list");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.found) |-> (out_q.nearest_dist == '0 && out_q.best_index == '0))
    else $error("empty-list result not zero");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside finish step");

endmodule

// ===== sv/npcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module npcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
